[rtl/frd_pkg.sv]
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the filter regeneration event detector
// Phase encoding, configuration register map, reset values and the constant
// reciprocal used to turn milliseconds into seconds.
// ----------------------------------------------------------------------------
package frd_pkg;

  // Field widths
  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned SOOT_W     = 16;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned TOTAL_W    = 40;
  localparam int unsigned DUR_W      = 23;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // x / 1000 == (x * DIV1000_MUL) >> DIV1000_SHIFT, exact for every 32-bit x
  localparam int unsigned DIV1000_MUL_W = 29;
  localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;
  localparam int unsigned DIV1000_SHIFT = 38;
  localparam int unsigned DIV_PROD_W    = MS_W + DIV1000_MUL_W;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TEMP    = 3'd0,
    CFG_OFF_TEMP   = 3'd1,
    CFG_CONFIRM_MS = 3'd2,
    CFG_END_MS     = 3'd3,
    CFG_GAP_MS     = 3'd4,
    CFG_SAVE_EVERY = 3'd5
  } cfg_idx_e;

  // Configuration reset values
  localparam logic signed [TEMP_W-1:0] ON_TEMP_RST    = 15'sd5500;
  localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST   = 15'sd4500;
  localparam logic [MS_W-1:0]          CONFIRM_MS_RST = 32'd60000;
  localparam logic [MS_W-1:0]          END_MS_RST     = 32'd60000;
  localparam logic [MS_W-1:0]          GAP_MS_RST     = 32'd10000;
  localparam logic [DIST_W-1:0]        SAVE_EVERY_RST = 32'd1000;

  // Detector phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CAND   = 4'b0010,
    PH_ACTIVE = 4'b0100,
    PH_ENDING = 4'b1000
  } phase_e;

  // Phase codes as seen on the result channel
  localparam logic [PHASE_W-1:0] PHC_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHC_CAND   = 2'd1;
  localparam logic [PHASE_W-1:0] PHC_ACTIVE = 2'd2;
  localparam logic [PHASE_W-1:0] PHC_ENDING = 2'd3;

  // Result register contents
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [31:0]        regen_count;
    logic [DUR_W-1:0]   last_duration_s;
    logic [SOOT_W-1:0]  last_soot_burned;
    logic [DIST_W-1:0]  distance_since_m;
    logic [TOTAL_W-1:0] distance_total_m;
    logic               started;
    logic               completed;
    logic               save_distance;
  } frd_res_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_e ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_IDLE:   code = PHC_IDLE;
      PH_CAND:   code = PHC_CAND;
      PH_ACTIVE: code = PHC_ACTIVE;
      PH_ENDING: code = PHC_ENDING;
      default:   code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

[rtl/frd_sample_if.sv]
// ----------------------------------------------------------------------------
// frd_sample_if: sensor sample channel
// Valid/ready channel carrying one trip, time, temperature and soot sample.
// ----------------------------------------------------------------------------
interface frd_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        trip_m;
  logic [31:0]        now_ms;
  logic               temp_valid;
  logic signed [14:0] temperature;
  logic               soot_valid;
  logic [15:0]        soot_load;

  modport source (
    output valid, trip_m, now_ms, temp_valid, temperature, soot_valid, soot_load,
    input  ready
  );
  modport sink (
    input  valid, trip_m, now_ms, temp_valid, temperature, soot_valid, soot_load,
    output ready
  );
endinterface

[rtl/frd_result_if.sv]
// ----------------------------------------------------------------------------
// frd_result_if: detector result channel
// Valid/ready channel carrying the detector status after one sample.
// ----------------------------------------------------------------------------
interface frd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [31:0] regen_count;
  logic [22:0] last_duration_s;
  logic [15:0] last_soot_burned;
  logic [31:0] distance_since_m;
  logic [39:0] distance_total_m;
  logic        started_pulse;
  logic        completed_pulse;
  logic        save_distance_pulse;

  modport source (
    output valid, phase, regen_count, last_duration_s, last_soot_burned,
           distance_since_m, distance_total_m, started_pulse, completed_pulse,
           save_distance_pulse,
    input  ready
  );
  modport sink (
    input  valid, phase, regen_count, last_duration_s, last_soot_burned,
           distance_since_m, distance_total_m, started_pulse, completed_pulse,
           save_distance_pulse,
    output ready
  );
endinterface

[rtl/filter_regen_event_detector.sv]
// ----------------------------------------------------------------------------
// filter_regen_event_detector: particulate filter regeneration detector
// Tracks distance since the last regeneration, raises distance save requests
// and detects regeneration start and completion with hysteresis windows.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          contents
//   sample    in   valid/ready        trip, timestamp, temperature, soot load
//   result    out  valid/ready        phase, counters, durations, pulses
//   cfg       in   cfg_we_i           threshold, window and save-interval registers
//
// One sample per cycle while the result is not stalled; a sample passes the
// input register, then the result register. The phase and distance update is
// a single pass of compare/add logic; the ms-to-s conversion is one constant
// multiply. Reset puts handshake, detector state and configuration at their
// defaults; the input payload and result register are not reset. A stalled
// result holds the result register; the input register accepts until full.
// ----------------------------------------------------------------------------
module filter_regen_event_detector
  import frd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  frd_sample_if.sink            sample,
  frd_result_if.source          result,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic signed [TEMP_W-1:0] on_temp_q, off_temp_q;
  logic [MS_W-1:0]          confirm_ms_q, end_ms_q, gap_ms_q;
  logic [DIST_W-1:0]        save_every_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_temp_q    <= ON_TEMP_RST;
      off_temp_q   <= OFF_TEMP_RST;
      confirm_ms_q <= CONFIRM_MS_RST;
      end_ms_q     <= END_MS_RST;
      gap_ms_q     <= GAP_MS_RST;
      save_every_q <= SAVE_EVERY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ON_TEMP:    on_temp_q    <= cfg_data_i[TEMP_W-1:0];
        CFG_OFF_TEMP:   off_temp_q   <= cfg_data_i[TEMP_W-1:0];
        CFG_CONFIRM_MS: confirm_ms_q <= cfg_data_i[MS_W-1:0];
        CFG_END_MS:     end_ms_q     <= cfg_data_i[MS_W-1:0];
        CFG_GAP_MS:     gap_ms_q     <= cfg_data_i[MS_W-1:0];
        CFG_SAVE_EVERY: save_every_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds result register
  logic in_valid_q, out_valid_q;
  logic advance, step_en;

  assign advance      = !out_valid_q || result.ready;
  assign step_en      = in_valid_q && advance;
  assign sample.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample.ready) in_valid_q <= sample.valid;
      if (advance)      out_valid_q <= in_valid_q;
    end
  end

  // Input register payload
  logic [DIST_W-1:0]        trip_q;
  logic [MS_W-1:0]          now_q;
  logic                     t_ok_q, s_ok_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [SOOT_W-1:0]        soot_q;

  always_ff @(posedge clk_i) begin
    if (sample.valid && sample.ready) begin
      trip_q <= sample.trip_m;
      now_q  <= sample.now_ms;
      t_ok_q <= sample.temp_valid;
      temp_q <= sample.temperature;
      s_ok_q <= sample.soot_valid;
      soot_q <= sample.soot_load;
    end
  end

  // Detector state
  phase_e             phase_q, phase_d;
  logic [MS_W-1:0]    window_q, window_d;
  logic [MS_W-1:0]    regen_start_q, regen_start_d;
  logic [MS_W-1:0]    last_valid_q, last_valid_d;
  logic [DIST_W-1:0]  prev_trip_q;
  logic [DIST_W-1:0]  since_q, since_d;
  logic [DIST_W-1:0]  unsaved_q, unsaved_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [31:0]        count_q, count_d;
  logic [DUR_W-1:0]   dur_s_q, dur_s_d;
  logic [SOOT_W-1:0]  soot_start_q, soot_start_d;
  logic               soot_known_q, soot_known_d;
  logic [SOOT_W-1:0]  burned_q, burned_d;

  // Step datapath
  logic                  trip_gt;
  logic [DIST_W-1:0]     trip_delta;
  logic [DIST_W:0]       since_sum, unsaved_sum;
  logic [DIST_W-1:0]     since_acc, unsaved_acc;
  logic                  saved;
  logic [MS_W-1:0]       gap_elapsed, win_eff, win_elapsed, dur_ms;
  logic                  gap_hit, temp_hot, temp_cool;
  logic [DIV_PROD_W-1:0] dur_prod;
  logic [TOTAL_W:0]      total_sum;
  logic                  started, completed;

  always_comb begin
    // distance accumulation with saturation
    trip_gt     = trip_q > prev_trip_q;
    trip_delta  = trip_q - prev_trip_q;
    since_sum   = {1'b0, since_q} + {1'b0, trip_delta};
    unsaved_sum = {1'b0, unsaved_q} + {1'b0, trip_delta};
    since_acc   = since_q;
    unsaved_acc = unsaved_q;
    if (trip_gt) begin
      since_acc   = since_sum[DIST_W] ? '1 : since_sum[DIST_W-1:0];
      unsaved_acc = unsaved_sum[DIST_W] ? '1 : unsaved_sum[DIST_W-1:0];
    end
    saved = unsaved_acc >= save_every_q;

    // data gap restarts a pending window
    gap_elapsed = now_q - last_valid_q;
    gap_hit     = (last_valid_q != '0) && (gap_elapsed > gap_ms_q) &&
                  (phase_q == PH_CAND || phase_q == PH_ENDING);
    win_eff     = gap_hit ? now_q : window_q;
    win_elapsed = now_q - win_eff;
    temp_hot    = temp_q >= on_temp_q;
    temp_cool   = temp_q < off_temp_q;

    // regeneration length in seconds, divide by 1000 via reciprocal
    dur_ms    = win_eff - regen_start_q;
    dur_prod  = DIV_PROD_W'(dur_ms) * DIV_PROD_W'(DIV1000_MUL);
    total_sum = {1'b0, total_q} + TOTAL_W'(since_acc) + (TOTAL_W+1)'(0);

    phase_d       = phase_q;
    window_d      = window_q;
    regen_start_d = regen_start_q;
    last_valid_d  = last_valid_q;
    since_d       = since_acc;
    unsaved_d     = saved ? '0 : unsaved_acc;
    total_d       = total_q;
    count_d       = count_q;
    dur_s_d       = dur_s_q;
    soot_start_d  = soot_start_q;
    soot_known_d  = soot_known_q;
    burned_d      = burned_q;
    started       = 1'b0;
    completed     = 1'b0;

    if (t_ok_q) begin
      window_d     = win_eff;
      last_valid_d = now_q;
      case (phase_q)
        PH_IDLE: begin
          if (temp_hot) begin
            phase_d      = PH_CAND;
            window_d     = now_q;
            soot_known_d = s_ok_q;
            soot_start_d = s_ok_q ? soot_q : '0;
          end
        end
        PH_CAND: begin
          if (!temp_hot) begin
            phase_d = PH_IDLE;
          end else if (win_elapsed >= confirm_ms_q) begin
            phase_d       = PH_ACTIVE;
            regen_start_d = win_eff;
            started       = 1'b1;
          end
        end
        PH_ACTIVE: begin
          if (temp_cool) begin
            phase_d  = PH_ENDING;
            window_d = now_q;
          end
        end
        PH_ENDING: begin
          if (temp_hot) begin
            phase_d = PH_ACTIVE;
          end else if (win_elapsed >= end_ms_q) begin
            // regeneration complete: count, record, fold distance
            count_d   = count_q + 32'd1;
            dur_s_d   = dur_prod[DIV1000_SHIFT +: DUR_W];
            burned_d  = (soot_known_q && s_ok_q && soot_start_q > soot_q) ?
                        (soot_start_q - soot_q) : '0;
            total_d   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            since_d   = '0;
            unsaved_d = '0;
            phase_d   = PH_IDLE;
            completed = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      window_q      <= '0;
      regen_start_q <= '0;
      last_valid_q  <= '0;
      prev_trip_q   <= '0;
      since_q       <= '0;
      unsaved_q     <= '0;
      total_q       <= '0;
      count_q       <= '0;
      dur_s_q       <= '0;
      soot_start_q  <= '0;
      soot_known_q  <= 1'b0;
      burned_q      <= '0;
    end else if (step_en) begin
      phase_q       <= phase_d;
      window_q      <= window_d;
      regen_start_q <= regen_start_d;
      last_valid_q  <= last_valid_d;
      prev_trip_q   <= trip_q;
      since_q       <= since_d;
      unsaved_q     <= unsaved_d;
      total_q       <= total_d;
      count_q       <= count_d;
      dur_s_q       <= dur_s_d;
      soot_start_q  <= soot_start_d;
      soot_known_q  <= soot_known_d;
      burned_q      <= burned_d;
    end
  end

  // Result register
  frd_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q.phase            <= phase_code(phase_d);
      res_q.regen_count      <= count_d;
      res_q.last_duration_s  <= dur_s_d;
      res_q.last_soot_burned <= burned_d;
      res_q.distance_since_m <= since_d;
      res_q.distance_total_m <= total_d;
      res_q.started          <= started;
      res_q.completed        <= completed;
      res_q.save_distance    <= saved;
    end
  end

  assign result.valid               = out_valid_q;
  assign result.phase               = res_q.phase;
  assign result.regen_count         = res_q.regen_count;
  assign result.last_duration_s     = res_q.last_duration_s;
  assign result.last_soot_burned    = res_q.last_soot_burned;
  assign result.distance_since_m    = res_q.distance_since_m;
  assign result.distance_total_m    = res_q.distance_total_m;
  assign result.started_pulse       = res_q.started;
  assign result.completed_pulse     = res_q.completed;
  assign result.save_distance_pulse = res_q.save_distance;

  // Assertions
  a_start_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.started && res_q.completed))
    else $error("start and completion flagged by one sample");

  a_complete_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.completed) |->
      (res_q.phase == PHC_IDLE && res_q.distance_since_m == '0))
    else $error("completion without return to idle and distance clear");

  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.started) |-> (res_q.phase == PHC_ACTIVE))
    else $error("start confirmed outside active phase");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && completed) |=> (count_q == $past(count_q) + 32'd1))
    else $error("regeneration count did not advance on completion");

endmodule

[tb/frd_status_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frd_status_checker: scoreboard for the filter regeneration event detector
// Watches the sample, result and configuration ports, forecasts the detector
// status for every accepted sample request and compares each accepted result
// field by field against the oldest forecast.
// ----------------------------------------------------------------------------
module frd_status_checker
  import frd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  frd_sample_if                 sample_i,
  frd_result_if                 result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    outstanding_o,
  output int                    mismatch_cnt_o
);

  localparam logic [31:0] MS_PER_S = 32'd1000;

  // Shadow configuration
  logic signed [TEMP_W-1:0] hot_t;
  logic signed [TEMP_W-1:0] cool_t;
  logic [MS_W-1:0]          confirm_win;
  logic [MS_W-1:0]          end_win;
  logic [MS_W-1:0]          gap_win;
  logic [DIST_W-1:0]        save_step;

  // Shadow detector state
  logic [PHASE_W-1:0] ph;
  logic [MS_W-1:0]    win_t0;
  logic [MS_W-1:0]    regen_t0;
  logic [MS_W-1:0]    last_seen;
  logic [DIST_W-1:0]  trip_prev;
  logic [DIST_W-1:0]  dist_since;
  logic [DIST_W-1:0]  dist_unsaved;
  logic [TOTAL_W-1:0] dist_total;
  logic [31:0]        regen_cnt;
  logic [DUR_W-1:0]   dur_s;
  logic [SOOT_W-1:0]  soot_t0;
  logic               soot_t0_ok;
  logic [SOOT_W-1:0]  soot_burnt;

  frd_res_t status_q[$];
  int       fails;

  // Advance the shadow detector by one sample and return the status it reports
  task automatic predict_status(input logic [31:0] trip, input logic [31:0] now,
                                input logic t_ok, input logic signed [TEMP_W-1:0] t,
                                input logic s_ok, input logic [SOOT_W-1:0] soot,
                                output frd_res_t st);
    logic [32:0] sum;
    logic [40:0] tot;
    logic [31:0] span;
    logic        started, completed, saved;
    started   = 1'b0;
    completed = 1'b0;
    saved     = 1'b0;

    // distance bookkeeping, saturating
    if (trip > trip_prev) begin
      sum          = {1'b0, dist_since} + {1'b0, trip - trip_prev};
      dist_since   = sum[32] ? '1 : sum[31:0];
      sum          = {1'b0, dist_unsaved} + {1'b0, trip - trip_prev};
      dist_unsaved = sum[32] ? '1 : sum[31:0];
    end
    trip_prev = trip;
    if (dist_unsaved >= save_step) begin
      saved        = 1'b1;
      dist_unsaved = '0;
    end

    // phase machine, only on a valid temperature
    if (t_ok) begin
      // stale data restarts a pending window
      if (last_seen != '0 && (now - last_seen) > gap_win &&
          (ph == PHC_CAND || ph == PHC_ENDING)) begin
        win_t0 = now;
      end
      last_seen = now;
      case (ph)
        PHC_IDLE: begin
          if (t >= hot_t) begin
            ph         = PHC_CAND;
            win_t0     = now;
            soot_t0_ok = s_ok;
            soot_t0    = s_ok ? soot : '0;
          end
        end
        PHC_CAND: begin
          if (t < hot_t) begin
            ph = PHC_IDLE;
          end else if ((now - win_t0) >= confirm_win) begin
            ph       = PHC_ACTIVE;
            regen_t0 = win_t0;
            started  = 1'b1;
          end
        end
        PHC_ACTIVE: begin
          if (t < cool_t) begin
            ph     = PHC_ENDING;
            win_t0 = now;
          end
        end
        default: begin
          if (t >= hot_t) begin
            ph = PHC_ACTIVE;
          end else if ((now - win_t0) >= end_win) begin
            regen_cnt    = regen_cnt + 32'd1;
            span         = win_t0 - regen_t0;
            span         = span / MS_PER_S;
            dur_s        = span[DUR_W-1:0];
            soot_burnt   = (soot_t0_ok && s_ok && soot_t0 > soot) ? soot_t0 - soot : '0;
            tot          = {1'b0, dist_total} + {9'd0, dist_since};
            dist_total   = tot[40] ? '1 : tot[39:0];
            dist_since   = '0;
            dist_unsaved = '0;
            ph           = PHC_IDLE;
            completed    = 1'b1;
          end
        end
      endcase
    end

    st.phase            = ph;
    st.regen_count      = regen_cnt;
    st.last_duration_s  = dur_s;
    st.last_soot_burned = soot_burnt;
    st.distance_since_m = dist_since;
    st.distance_total_m = dist_total;
    st.started          = started;
    st.completed        = completed;
    st.save_distance    = saved;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frd_res_t want, st;
    if (!rst_ni) begin
      hot_t          = ON_TEMP_RST;
      cool_t         = OFF_TEMP_RST;
      confirm_win    = CONFIRM_MS_RST;
      end_win        = END_MS_RST;
      gap_win        = GAP_MS_RST;
      save_step      = SAVE_EVERY_RST;
      ph             = PHC_IDLE;
      win_t0         = '0;
      regen_t0       = '0;
      last_seen      = '0;
      trip_prev      = '0;
      dist_since     = '0;
      dist_unsaved   = '0;
      dist_total     = '0;
      regen_cnt      = '0;
      dur_s          = '0;
      soot_t0        = '0;
      soot_t0_ok     = 1'b0;
      soot_burnt     = '0;
      fails          = 0;
      status_q.delete();
      outstanding_o  <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      // register writes land on the same edge as in the block
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ON_TEMP:    hot_t       = cfg_data_i[TEMP_W-1:0];
          CFG_OFF_TEMP:   cool_t      = cfg_data_i[TEMP_W-1:0];
          CFG_CONFIRM_MS: confirm_win = cfg_data_i;
          CFG_END_MS:     end_win     = cfg_data_i;
          CFG_GAP_MS:     gap_win     = cfg_data_i;
          CFG_SAVE_EVERY: save_step   = cfg_data_i;
          default: ;
        endcase
      end

      // compare an accepted result against the oldest forecast
      if (result_i.valid && result_i.ready) begin
        if (status_q.size() == 0) begin
          fails++;
          $display("%0t: result with no sample request outstanding", $time);
        end else begin
          want = status_q.pop_front();
          check_field("phase", want.phase, result_i.phase);
          check_field("regen_count", want.regen_count, result_i.regen_count);
          check_field("last_duration_s", want.last_duration_s, result_i.last_duration_s);
          check_field("last_soot_burned", want.last_soot_burned,
                      result_i.last_soot_burned);
          check_field("distance_since_m", want.distance_since_m,
                      result_i.distance_since_m);
          check_field("distance_total_m", want.distance_total_m,
                      result_i.distance_total_m);
          check_field("started_pulse", want.started, result_i.started_pulse);
          check_field("completed_pulse", want.completed, result_i.completed_pulse);
          check_field("save_distance_pulse", want.save_distance,
                      result_i.save_distance_pulse);
        end
      end

      // forecast for an accepted sample request
      if (sample_i.valid && sample_i.ready) begin
        predict_status(sample_i.trip_m, sample_i.now_ms, sample_i.temp_valid,
                       sample_i.temperature, sample_i.soot_valid, sample_i.soot_load, st);
        status_q.push_back(st);
      end

      outstanding_o  <= status_q.size();
      mismatch_cnt_o <= fails;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the filter regeneration event detector
// Drives directed and randomized sensor samples through several threshold
// and window settings, with random idling on both channels, and reports the
// verdict from the status checker running beside the block.
// ----------------------------------------------------------------------------
module tb_top
  import frd_pkg::*;
;

  localparam int TEMP_MIN   = -400;
  localparam int TEMP_MAX   = 12000;
  localparam int CYCLE_CAP  = 400000;

  typedef enum logic [1:0] {TK_COOL, TK_MID, TK_HOT, TK_ANY} temp_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int outstanding;
  int mismatch_cnt;
  int cycles;

  // Idle percentages of sender and receiver
  int src_idle_pct  = 37;
  int sink_idle_pct = 58;

  // Stimulus state: the running odometer and clock, and the active thresholds
  logic [31:0] trip_m;
  logic [31:0] now_ms;
  logic [31:0] cur_gap = 32'd10000;
  int          cur_on  = 5500;
  int          cur_off = 4500;
  int          trip_step = 400;

  frd_sample_if smp ();
  frd_result_if res ();

  filter_regen_event_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample     (smp),
    .result     (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  frd_status_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (smp),
    .result_i       (res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .outstanding_o  (outstanding),
    .mismatch_cnt_o (mismatch_cnt)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result receiver with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one sample request and hold it until accepted
  task automatic offer_sample(input logic [31:0] trip, input logic [31:0] now,
                              input logic tv, input int temp,
                              input logic sv, input logic [15:0] soot);
    while ($urandom_range(99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid       <= 1'b1;
    smp.trip_m      <= trip;
    smp.now_ms      <= now;
    smp.temp_valid  <= tv;
    smp.temperature <= 15'(temp);
    smp.soot_valid  <= sv;
    smp.soot_load   <= soot;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  // Wait until every forecast status has come back
  task automatic drain();
    smp.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int on_t, input int off_t, input logic [31:0] confirm,
                            input logic [31:0] endw, input logic [31:0] gap,
                            input logic [31:0] save);
    cfg_write(CFG_ON_TEMP, 32'(on_t));
    cfg_write(CFG_OFF_TEMP, 32'(off_t));
    cfg_write(CFG_CONFIRM_MS, confirm);
    cfg_write(CFG_END_MS, endw);
    cfg_write(CFG_GAP_MS, gap);
    cfg_write(CFG_SAVE_EVERY, save);
    cfg_we  <= 1'b0;
    cur_on  = on_t;
    cur_off = off_t;
    cur_gap = gap;
  endtask

  // Temperature in a band relative to the active thresholds, ends favored
  function automatic int pick_temp(input temp_kind_e k);
    int lo, hi;
    lo = TEMP_MIN;
    hi = TEMP_MAX;
    case (k)
      TK_COOL: hi = cur_off - 1;
      TK_MID: begin
        lo = cur_off;
        hi = cur_on - 1;
      end
      TK_HOT:  lo = cur_on;
      default: ;
    endcase
    if (lo < TEMP_MIN) lo = TEMP_MIN;
    if (hi > TEMP_MAX) hi = TEMP_MAX;
    if (lo > hi) begin
      lo = TEMP_MIN;
      hi = TEMP_MAX;
    end
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  // One random sample: time mostly advances within the window, sometimes jumps
  // past the gap; the odometer mostly climbs, sometimes falls or leaps
  task automatic random_sample(input temp_kind_e k, input int dt_max);
    int pick;
    pick = $urandom_range(11);
    if (pick == 0) now_ms = now_ms + cur_gap + $urandom_range(dt_max, 1);
    else           now_ms = now_ms + $urandom_range(dt_max);
    pick = $urandom_range(19);
    if (pick < 16)      trip_m = trip_m + $urandom_range(trip_step);
    else if (pick < 18) trip_m = $urandom_range(trip_m);
    else                trip_m = $urandom;
    offer_sample(trip_m, now_ms, $urandom_range(9) != 0, pick_temp(k),
                 $urandom_range(9) != 0, 16'($urandom));
  endtask

  // Mostly heat-up / hold / cool-down episodes, the rest single noise samples
  task automatic random_run(input int n_items, input int dt_max);
    int left, lead_n, hot_n, mid_n, cool_n;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(4) == 0) begin
        random_sample(TK_ANY, dt_max);
        left--;
      end else begin
        lead_n = $urandom_range(2);
        hot_n  = $urandom_range(6, 1);
        mid_n  = $urandom_range(3);
        cool_n = $urandom_range(6, 1);
        repeat (lead_n) random_sample(TK_COOL, dt_max);
        repeat (hot_n) random_sample(TK_HOT, dt_max);
        repeat (mid_n) random_sample($urandom_range(1) ? TK_MID : TK_HOT, dt_max);
        repeat (cool_n) random_sample($urandom_range(4) ? TK_COOL : TK_MID, dt_max);
        left -= lead_n + hot_n + mid_n + cool_n;
      end
    end
  endtask

  // Back-to-back shortest regenerations with the odometer swinging end to
  // end, so each one folds a saturated distance into the total
  task automatic total_haul(input int n_regen);
    repeat (n_regen) begin
      now_ms = now_ms + $urandom_range(50, 1);
      offer_sample('1, now_ms, 1'b1, pick_temp(TK_HOT), 1'b1, 16'($urandom));
      now_ms = now_ms + $urandom_range(50, 1);
      offer_sample('0, now_ms, 1'b1, pick_temp(TK_HOT), 1'b1, 16'($urandom));
      now_ms = now_ms + $urandom_range(50, 1);
      offer_sample('1, now_ms, 1'b1, pick_temp(TK_COOL), 1'b1, 16'($urandom));
      now_ms = now_ms + $urandom_range(50, 1);
      offer_sample('0, now_ms, 1'b1, pick_temp(TK_COOL), 1'b1, 16'($urandom));
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_ON_TEMP;
    cfg_data        <= '0;
    smp.valid       <= 1'b0;
    smp.trip_m      <= '0;
    smp.now_ms      <= '0;
    smp.temp_valid  <= 1'b0;
    smp.temperature <= '0;
    smp.soot_valid  <= 1'b0;
    smp.soot_load   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset thresholds: sample at time zero, first sample after
    // it skips the gap check, stale candidate window, odometer drop, invalid
    // temperature, distance saturation
    offer_sample(32'd0, 32'd0, 1'b1, TEMP_MIN, 1'b1, 16'd0);
    offer_sample(32'd500, 32'd20000, 1'b1, TEMP_MAX, 1'b1, 16'hFFFF);
    offer_sample(32'd1500, 32'd40000, 1'b1, 6000, 1'b1, 16'd40000);
    offer_sample(32'd1000, 32'd45000, 1'b0, 0, 1'b0, 16'd0);
    offer_sample(32'hFFFF_FFFF, 32'd50000, 1'b1, 4000, 1'b1, 16'd100);
    offer_sample(32'd0, 32'd50001, 1'b0, 0, 1'b1, 16'd100);
    offer_sample(32'hFFFF_FFFF, 32'd50002, 1'b0, 0, 1'b1, 16'd100);

    // Short windows: start across the clock wrap, ending held between the
    // thresholds, reheat, stale ending window, completion with known and
    // unknown soot
    drain();
    set_config(5500, 4500, 32'd1000, 32'd2000, 32'd10000, 32'd1000);
    offer_sample(32'd100, 32'hFFFF_FF00, 1'b1, 5500, 1'b1, 16'd30000);
    offer_sample(32'd300, 32'h0000_0300, 1'b1, 5600, 1'b1, 16'd29000);
    offer_sample(32'd800, 32'h0000_0500, 1'b1, 4500, 1'b1, 16'd25000);
    offer_sample(32'd1900, 32'h0000_0600, 1'b1, 4499, 1'b0, 16'd0);
    offer_sample(32'd1900, 32'h0000_0700, 1'b1, 5000, 1'b1, 16'd20000);
    offer_sample(32'd2000, 32'h0000_0800, 1'b1, 5500, 1'b1, 16'd20000);
    offer_sample(32'd2100, 32'h0000_0900, 1'b1, 100, 1'b1, 16'd15000);
    offer_sample(32'd2200, 32'd17304, 1'b1, 100, 1'b1, 16'd12000);
    offer_sample(32'd2300, 32'd19804, 1'b1, 4000, 1'b1, 16'd10000);
    offer_sample(32'd2400, 32'd19904, 1'b1, 8000, 1'b0, 16'd9000);
    offer_sample(32'd2500, 32'd20904, 1'b1, 8000, 1'b1, 16'd8000);
    offer_sample(32'd2600, 32'd21004, 1'b1, TEMP_MIN, 1'b1, 16'd7000);
    offer_sample(32'd2700, 32'd23004, 1'b1, 0, 1'b1, 16'd5);

    // Random regeneration traffic under several settings
    trip_m = 32'd2700;
    now_ms = 32'd100000;
    drain();
    set_config(3000, 2000, 32'd500, 32'd800, 32'd300, 32'd1);
    random_run(100, 250);

    src_idle_pct  = 58;
    sink_idle_pct = 37;
    drain();
    set_config(TEMP_MAX, TEMP_MIN, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    random_run(80, 50);
    drain();
    set_config(TEMP_MIN, TEMP_MAX, '1, '1, '1, 32'd5000);
    random_run(50, 1000000);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    drain();
    set_config(5000, 4000, 32'd2000, 32'd3000, 32'd1500, 32'd700);
    random_run(80, 1200);
    drain();
    set_config(100, 50, 32'd0, 32'd0, 32'd10000, 32'd123456);
    total_haul(18);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/frd_pkg.sv
rtl/frd_sample_if.sv
rtl/frd_result_if.sv
rtl/filter_regen_event_detector.sv
tb/frd_status_checker.sv
tb/tb_top.sv
